/* rtl/ckcl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ckcl_pkg;

    // key table
    localparam int MAX_KEYS = 16;
    localparam int KEY_AW   = 4;
    localparam int CNT_W    = 5;
    localparam int TIME_W   = 13;
    localparam int COL_W    = 24;
    localparam int LVL_W    = 16;

    // one day in 1/256 hour units
    localparam int DAY_UNITS = 6144;

    // signed span / elapsed, magnitudes below 2^14
    localparam int SPAN_W = 15;
    localparam int DIV_W  = 14;

    // ratio is Q0.16 with room for exactly 1.0
    localparam int QUO_W    = 16;
    localparam int RATIO_W  = 17;
    localparam int DIV_BITS = 2;
    localparam int DIV_STEPS = QUO_W / DIV_BITS;
    localparam int DSTEP_W  = $clog2(DIV_STEPS);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [TIME_W-1:0] key_time_t;
    typedef logic [COL_W-1:0]  key_col_t;
    typedef logic [LVL_W-1:0]  key_lvl_t;
    typedef logic signed [SPAN_W-1:0] span_t;

    // divider request from the sequencer
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/ckcl_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, dividend below divisor, two quotient bits a cycle
module ckcl_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  ckcl_pkg::div_req_t  req,
    output ckcl_pkg::div_rsp_t  rsp
);
    import ckcl_pkg::*;

    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   dsr_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DSTEP_W-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_W-1:0]   rem_next;
    logic [QUO_W-1:0]   quo_next;
    logic [DIV_W:0]     shifted;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        shifted  = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            shifted = {rem_next, 1'b0};
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = DIV_W'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_next[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_next[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DSTEP_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend;
            dsr_reg <= req.divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/cyclic_keyframe_color_lerp.sv */
`timescale 1ns / 1ps
`default_nettype none

// Day-cycle light blender over a table of up to 16 keyframes.
// Input channel (s_valid / s_ready): s_cmd load writes key s_key_index from
// the key fields in the cycle it is taken and yields no result; s_cmd query
// gives s_query_time and yields one result on the m_ channel.
// key_count is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block idles, since the block itself has no guard for it;
// 0 acts as one key and values above 16 as 16. A query walks the key times one
// per cycle through the table read port until the segment is found, reads the
// two end keys, divides elapsed time by span in a radix-4 divider (skipped when
// the ratio is 0 or 1.0) and blends the four channels through one shared
// multiplier. s_ready stays low from a query transfer until the query leaves
// its last step.
// The result waits in an output register until m_ready; while it waits the
// block takes the next item, and a further query holds in its last step.
// Reset (aresetn low, synchronous) clears control and sets key_count to 1;
// the key table is not cleared and must be loaded before use.
module cyclic_keyframe_color_lerp (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire [ckcl_pkg::CNT_W-1:0]   cfg_wr_data,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire                         s_cmd,
    input  wire [ckcl_pkg::KEY_AW-1:0]  s_key_index,
    input  wire [ckcl_pkg::TIME_W-1:0]  s_key_time,
    input  wire [7:0]                   s_key_red,
    input  wire [7:0]                   s_key_green,
    input  wire [7:0]                   s_key_blue,
    input  wire [ckcl_pkg::LVL_W-1:0]   s_key_intensity,
    input  wire [ckcl_pkg::TIME_W-1:0]  s_query_time,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [7:0]                  m_out_red,
    output logic [7:0]                  m_out_green,
    output logic [7:0]                  m_out_blue,
    output logic [ckcl_pkg::LVL_W-1:0]  m_out_intensity,
    output logic [ckcl_pkg::KEY_AW-1:0] m_segment_start
);
    import ckcl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_RDB   = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_BLEND = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << QUO_W);
    localparam span_t DAY_S = SPAN_W'(DAY_UNITS);

    // key table
    key_time_t time_mem [MAX_KEYS];
    key_col_t  col_mem  [MAX_KEYS];
    key_lvl_t  lvl_mem  [MAX_KEYS];

    logic [KEY_AW-1:0] rd_addr;
    key_time_t rd_time_reg;
    key_col_t  rd_col_reg;
    key_lvl_t  rd_lvl_reg;

    logic [2:0]         state_reg;
    logic [CNT_W-1:0]   key_count_reg;
    logic [KEY_AW-1:0]  last_reg;
    logic [KEY_AW-1:0]  idx_reg;
    logic [KEY_AW-1:0]  start_reg;
    logic [KEY_AW-1:0]  end_reg;
    key_time_t          q_reg;
    key_time_t          prev_reg;
    key_time_t          t0_reg;
    span_t              span_reg;
    span_t              elap_reg;
    key_col_t           a_col_reg;
    key_lvl_t           a_lvl_reg;
    key_col_t           b_col_reg;
    key_lvl_t           b_lvl_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [2:0]         bl_cnt_reg;
    logic signed [LVL_W+RATIO_W+1:0] prod_reg;
    logic [7:0]         w_red_reg;
    logic [7:0]         w_green_reg;
    logic [7:0]         w_blue_reg;
    key_lvl_t           w_lvl_reg;
    logic               m_valid_reg;

    logic in_xfer;
    logic found;
    logic m_valid_next;
    logic [KEY_AW-1:0] last_next;
    span_t q_s, cur_s, prev_s, t0_s;
    span_t span_next, elap_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // blend datapath
    logic [1:0]  mul_ch, fin_ch;
    key_lvl_t    mul_a, mul_b, fin_a;
    logic signed [LVL_W:0] diff;
    logic signed [LVL_W+RATIO_W+1:0] prod_next;
    logic signed [LVL_W+RATIO_W+1:0] rounded;
    key_lvl_t    blend_res;

    function automatic key_lvl_t chan_sel(key_col_t col, key_lvl_t lvl, logic [1:0] ch);
        key_lvl_t v;
        v = '0;
        case (ch)
            2'd0:    v = LVL_W'(col[23:16]);
            2'd1:    v = LVL_W'(col[15:8]);
            2'd2:    v = LVL_W'(col[7:0]);
            2'd3:    v = lvl;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign in_xfer = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        if (key_count_reg == '0) begin
            last_next = '0;
        end else if (key_count_reg >= CNT_W'(MAX_KEYS)) begin
            last_next = KEY_AW'(MAX_KEYS - 1);
        end else begin
            last_next = KEY_AW'(key_count_reg - 1'b1);
        end
    end

    always_comb begin
        case (state_reg)
            S_SCAN:  rd_addr = idx_reg + 1'b1;
            S_RDA:   rd_addr = start_reg;
            S_RDB:   rd_addr = end_reg;
            default: rd_addr = '0;
        endcase
    end

    // segment test and span / elapsed for the key now on the read port
    always_comb begin
        q_s    = SPAN_W'({2'b00, q_reg});
        cur_s  = SPAN_W'({2'b00, rd_time_reg});
        prev_s = SPAN_W'({2'b00, prev_reg});
        t0_s   = (idx_reg == '0) ? cur_s : SPAN_W'({2'b00, t0_reg});
        found  = (idx_reg != '0) && (q_reg > prev_reg) && (q_reg <= rd_time_reg);
        if (found) begin
            span_next = cur_s - prev_s;
            elap_next = q_s - prev_s;
        end else begin
            // wrap segment from the last key round midnight to key 0
            span_next = t0_s + DAY_S - cur_s;
            if (q_reg > rd_time_reg) begin
                elap_next = q_s - cur_s;
            end else begin
                elap_next = DAY_S - cur_s + q_s;
            end
        end
    end

    assign div_req.start    = (state_reg == S_PREP) && (span_reg > 0) && (elap_reg > 0)
                              && (elap_reg < span_reg);
    assign div_req.dividend = elap_reg[DIV_W-1:0];
    assign div_req.divisor  = span_reg[DIV_W-1:0];

    ckcl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // a + ((b - a) * r + half) >>> 16, one channel multiplied per cycle
    always_comb begin
        mul_ch    = bl_cnt_reg[1:0];
        fin_ch    = 2'(bl_cnt_reg - 1'b1);
        mul_a     = chan_sel(a_col_reg, a_lvl_reg, mul_ch);
        mul_b     = chan_sel(b_col_reg, b_lvl_reg, mul_ch);
        fin_a     = chan_sel(a_col_reg, a_lvl_reg, fin_ch);
        diff      = $signed({1'b0, mul_b}) - $signed({1'b0, mul_a});
        prod_next = diff * $signed({1'b0, ratio_reg});
        rounded   = (prod_reg + (LVL_W+RATIO_W+2)'(1 << (QUO_W - 1))) >>> QUO_W;
        blend_res = LVL_W'(rounded) + fin_a;
    end

    // result valid drops on a transfer and rises when the last step finishes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_cmd == CMD_LOAD) begin
            time_mem[s_key_index] <= s_key_time;
            col_mem[s_key_index]  <= {s_key_red, s_key_green, s_key_blue};
            lvl_mem[s_key_index]  <= s_key_intensity;
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_col_reg  <= col_mem[rd_addr];
        rd_lvl_reg  <= lvl_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            key_count_reg <= CNT_W'(1);
            m_valid_reg   <= 1'b0;
            bl_cnt_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                key_count_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
            case (state_reg)
                S_IDLE: begin
                    if (in_xfer && s_cmd == CMD_QUERY) begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (found || idx_reg == last_reg) begin
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:  state_reg <= S_RDB;
                S_RDB:  state_reg <= S_PREP;
                S_PREP: begin
                    bl_cnt_reg <= '0;
                    state_reg  <= div_req.start ? S_DIV : S_BLEND;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    bl_cnt_reg <= bl_cnt_reg + 1'b1;
                    if (bl_cnt_reg == 3'd4) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                q_reg    <= s_query_time;
                last_reg <= last_next;
                idx_reg  <= '0;
            end
            S_SCAN: begin
                idx_reg  <= idx_reg + 1'b1;
                prev_reg <= rd_time_reg;
                if (idx_reg == '0) begin
                    t0_reg <= rd_time_reg;
                end
                span_reg <= span_next;
                elap_reg <= elap_next;
                if (found) begin
                    start_reg <= idx_reg - 1'b1;
                    end_reg   <= idx_reg;
                end else begin
                    start_reg <= idx_reg;
                    end_reg   <= '0;
                end
            end
            S_RDB: begin
                a_col_reg <= rd_col_reg;
                a_lvl_reg <= rd_lvl_reg;
            end
            S_PREP: begin
                b_col_reg <= rd_col_reg;
                b_lvl_reg <= rd_lvl_reg;
                if (span_reg <= 0 || elap_reg <= 0) begin
                    ratio_reg <= '0;
                end else if (elap_reg >= span_reg) begin
                    ratio_reg <= RATIO_ONE;
                end else begin
                    ratio_reg <= '0;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    ratio_reg <= RATIO_W'(div_rsp.quotient);
                end
            end
            S_BLEND: begin
                prod_reg <= prod_next;
                if (bl_cnt_reg != 3'd0) begin
                    case (fin_ch)
                        2'd0:    w_red_reg   <= blend_res[7:0];
                        2'd1:    w_green_reg <= blend_res[7:0];
                        2'd2:    w_blue_reg  <= blend_res[7:0];
                        2'd3:    w_lvl_reg   <= blend_res;
                        default: w_lvl_reg   <= blend_res;
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_out_red       <= w_red_reg;
            m_out_green     <= w_green_reg;
            m_out_blue      <= w_blue_reg;
            m_out_intensity <= w_lvl_reg;
            m_segment_start <= start_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_cmd == CMD_QUERY) |=> !s_ready)
        else $error("query transfer did not stall the input");

    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_cmd == CMD_LOAD) |=> s_ready)
        else $error("load transfer took more than one cycle");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BLEND) |-> (ratio_reg <= RATIO_ONE))
        else $error("blend ratio above one");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final step");

endmodule

`default_nettype wire
